// File: sv/dsef_pkg.sv
// ----------------------------------------------------------------------------
// dsef_pkg: shared definitions for the DLE/STX/ETX framer
// Register indexes, output slot codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package dsef_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 2;
	localparam int unsigned SLOT_N  = 7;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [INDEX_W-1:0] reg_index_t;
	typedef logic [SLOT_N-1:0]  slot_mask_t;

	// Configuration register indexes.
	localparam reg_index_t REG_ESCAPE = 2'd0;
	localparam reg_index_t REG_START  = 2'd1;
	localparam reg_index_t REG_END    = 2'd2;

	// Reset values of the registers.
	localparam byte_t ESCAPE_RESET = 8'h10;
	localparam byte_t START_RESET  = 8'h02;
	localparam byte_t END_RESET    = 8'h03;

	// CRC-8 constants.
	localparam byte_t CRC_INIT = 8'hFF;
	localparam byte_t CRC_POLY = 8'h31;

	// One-hot output slots, in the order they go out on the line.
	localparam slot_mask_t SLOT_OPEN_ESC  = 7'b0000001;
	localparam slot_mask_t SLOT_START     = 7'b0000010;
	localparam slot_mask_t SLOT_DATA      = 7'b0000100;
	localparam slot_mask_t SLOT_DATA_DUP  = 7'b0001000;
	localparam slot_mask_t SLOT_CRC       = 7'b0010000;
	localparam slot_mask_t SLOT_CLOSE_ESC = 7'b0100000;
	localparam slot_mask_t SLOT_END       = 7'b1000000;

	// Advance the CRC by one byte, MSB first, no final xor.
	function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
		byte_t v;
		v = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[BYTE_W-1]) begin
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[BYTE_W-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: sv/dle_stx_etx_framer_crc8.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_framer_crc8: byte-stuffing frame builder with CRC-8
// Wraps payload bytes in escape/start ... escape/end framing with a CRC.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input beat carries one payload byte and a flag marking the last byte of
// a frame. The first beat of a frame produces the escape code and the start
// code ahead of the payload byte. A payload byte equal to the escape code is
// sent twice. The last beat of a frame is followed by the CRC-8 of the
// unstuffed payload (polynomial 0x31, seed 0xFF, MSB first, sent unstuffed),
// then the escape code and the end code; frame_done marks the end code byte
// and run_last marks the final line byte produced by each input beat. An input
// beat therefore yields one to seven output beats. The block emits one line
// byte per cycle through a single output register when the output is not
// stalled, so an input beat occupies the block until all its line bytes are
// loaded: one line byte for a plain payload byte, two for a doubled escape
// byte, up to seven for a one-byte frame. The next input beat is taken in the
// same cycle the last line byte of the current one is loaded into the output
// register, so there is no bubble between beats. The escape, start
// and end codes are written through the wr_en/wr_index/wr_data port and should
// only change while the block is idle; index 3 is ignored.
module dle_stx_etx_framer_crc8 (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    wr_en,
	input  wire dsef_pkg::reg_index_t    wr_index,
	input  wire dsef_pkg::byte_t         wr_data,
	// input channel
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire dsef_pkg::byte_t         payload_byte,
	input  wire logic                    final_byte,
	// output channel
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output dsef_pkg::byte_t              line_byte,
	output logic                         run_last,
	output logic                         frame_done
);
	import dsef_pkg::*;

	// Configuration registers.
	byte_t escape_code_q;
	byte_t start_code_q;
	byte_t end_code_q;

	// Frame state.
	logic  in_frame_q;
	byte_t crc_q;

	// Held input beat: the byte, the CRC after it and the slots still to send.
	logic       item_valid_s1;
	byte_t      data_s1;
	byte_t      crc_s1;
	slot_mask_t mask_s1;

	// Output register.
	logic  out_valid_q;
	byte_t line_byte_q;
	logic  run_last_q;
	logic  frame_done_q;

	logic       in_acc;
	logic       load_out;
	logic       item_done;
	slot_mask_t pick;
	slot_mask_t remain;
	slot_mask_t new_mask;
	byte_t      crc_next;
	byte_t      pick_byte;

	// The output register can take a byte when it is empty or being drained.
	assign load_out  = item_valid_s1 && (!out_valid_q || !out_stall);
	// Lowest pending slot goes out first.
	assign pick      = mask_s1 & (~mask_s1 + slot_mask_t'(1));
	assign remain    = mask_s1 & ~pick;
	assign item_done = load_out && (remain == '0);
	assign in_stall  = item_valid_s1 && !item_done;
	assign in_acc    = in_valid && !in_stall;

	assign crc_next = crc8_update(crc_q, payload_byte);

	// Slots needed by an incoming beat.
	always_comb begin
		new_mask = SLOT_DATA;
		if (!in_frame_q) begin
			new_mask = new_mask | SLOT_OPEN_ESC | SLOT_START;
		end
		if (payload_byte == escape_code_q) begin
			new_mask = new_mask | SLOT_DATA_DUP;
		end
		if (final_byte) begin
			new_mask = new_mask | SLOT_CRC | SLOT_CLOSE_ESC | SLOT_END;
		end
	end

	always_comb begin
		case (pick)
			SLOT_OPEN_ESC:  pick_byte = escape_code_q;
			SLOT_START:     pick_byte = start_code_q;
			SLOT_DATA:      pick_byte = data_s1;
			SLOT_DATA_DUP:  pick_byte = escape_code_q;
			SLOT_CRC:       pick_byte = crc_s1;
			SLOT_CLOSE_ESC: pick_byte = escape_code_q;
			SLOT_END:       pick_byte = end_code_q;
			default:        pick_byte = data_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_code_q <= ESCAPE_RESET;
			start_code_q  <= START_RESET;
			end_code_q    <= END_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ESCAPE: escape_code_q <= wr_data;
				REG_START:  start_code_q  <= wr_data;
				REG_END:    end_code_q    <= wr_data;
				default:    ;
			endcase
		end
	end

	// Frame state advances when a beat is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q      <= CRC_INIT;
		end else if (in_acc) begin
			in_frame_q <= !final_byte;
			crc_q      <= final_byte ? CRC_INIT : crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			mask_s1       <= '0;
		end else if (in_acc) begin
			item_valid_s1 <= 1'b1;
			mask_s1       <= new_mask;
		end else if (item_done) begin
			item_valid_s1 <= 1'b0;
			mask_s1       <= '0;
		end else if (load_out) begin
			mask_s1 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= payload_byte;
			crc_s1  <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			line_byte_q  <= pick_byte;
			run_last_q   <= (remain == '0);
			frame_done_q <= (pick == SLOT_END);
		end
	end

	assign out_valid  = out_valid_q;
	assign line_byte  = line_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

	// A held beat always has at least one byte left to send.
	a_mask_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 |-> (mask_s1 != '0))
		else $error("held beat has no pending slots");

	// The end code is always the last byte of its input beat.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_done_q) |-> run_last_q)
		else $error("frame_done without run_last");

	// With no beat held the input is never stalled.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid_s1 |-> !in_stall)
		else $error("input stalled while empty");

	// Closing a frame reseeds the CRC.
	a_crc_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && final_byte) |=> (crc_q == CRC_INIT && !in_frame_q))
		else $error("CRC not reseeded after frame end");

	// A beat that opens a frame carries the escape and start slots.
	a_open_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_frame_q) |=> (mask_s1[0] && mask_s1[1]))
		else $error("frame opened without escape/start");

endmodule

`default_nettype wire
